// File: rtl/core/tts_pkg.sv
// shared types, constants and helpers of the triangle transform and shade core
package tts_pkg;

  localparam int unsigned CW      = 32;
  localparam int unsigned SUMW    = 66;
  localparam int unsigned TAGW    = 16;
  localparam int unsigned BUCKETW = 5;
  localparam int unsigned CFGIW   = 3;
  localparam int unsigned CFGDW   = 64;
  localparam int unsigned DIFFW   = 33;
  localparam int unsigned NW      = 66;
  localparam int unsigned DW      = 74;
  localparam int unsigned DMAGW   = 73;
  localparam int unsigned LEN2W   = 132;
  localparam int unsigned DSQW    = 146;

  // sun direction and light split in hundredths
  localparam int SUN_X       = -42;
  localparam int SUN_Y       = 33;
  localparam int SUN_Z       = 84;
  localparam int AMBIENT_PCT = 62;
  localparam int DIFFUSE_PCT = 38;

  typedef enum logic [CFGIW-1:0] {
    REG_XROW_A = 3'd0,
    REG_XROW_B = 3'd1,
    REG_YROW_A = 3'd2,
    REG_YROW_B = 3'd3,
    REG_ZROW_A = 3'd4,
    REG_ZROW_B = 3'd5
  } cfg_reg_e;

  localparam logic [CFGDW-1:0] XROW_A_RST = 64'h0001_0000_0000_0000;
  localparam logic [CFGDW-1:0] XROW_B_RST = 64'h0;
  localparam logic [CFGDW-1:0] YROW_A_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFGDW-1:0] YROW_B_RST = 64'h0;
  localparam logic [CFGDW-1:0] ZROW_A_RST = 64'h0;
  localparam logic [CFGDW-1:0] ZROW_B_RST = 64'h0001_0000_0000_0000;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    vec_t [2:0]      v;
    logic [TAGW-1:0] tag;
  } tri_t;

  typedef struct packed {
    logic [CFGDW-1:0] a;
    logic [CFGDW-1:0] b;
  } row_t;

  typedef struct packed {
    row_t [2:0] row;
  } matrix_t;

  // squared normal length and limb products of the sun dot product
  typedef struct packed {
    logic [LEN2W-1:0] len2;
    logic [49:0]      d00;
    logic [48:0]      d01;
    logic [48:0]      d02;
    logic [47:0]      d11;
    logic [47:0]      d12;
    logic [47:0]      d22;
    logic             pos;
  } face_t;

  function automatic coord_t sat_wide(input logic signed [SUMW-1:0] v);
    coord_t r;
    if (v > SUMW'(COORD_MAX)) r = COORD_MAX;
    else if (v < SUMW'(COORD_MIN)) r = COORD_MIN;
    else r = v[CW-1:0];
    return r;
  endfunction

  function automatic coord_t neg_sat(input coord_t v);
    coord_t r;
    if (v == COORD_MIN) r = COORD_MAX;
    else r = -v;
    return r;
  endfunction

endpackage

// File: rtl/core/triangle_transform_flat_shade_core.sv
// top level: matrix registers and the transform, normal and shade pipelines
//
// usage:
//   input channel: in_valid_i / in_ready_o carry one triangle beat, three
//   q16.16 vertices and a material tag. output channel: out_valid_o /
//   out_ready_i carry the transformed, axis-swapped vertices, the shade
//   bucket and the tag. config channel: cfg_valid_i / cfg_ready_o write one
//   64-bit matrix row register selected by cfg_index_i; it is always ready and
//   writes to unknown indexes are dropped. write it only while no beat is in
//   flight.
//   throughput is one beat per cycle while the receiver accepts. the pipeline
//   has two transform stages, five normal stages, two
//   shade setup stages and one stage per bucket bit of the search.
//   reset clears every stage valid and loads the identity transform.
//   when the receiver stalls, stages fill behind the held output beat one by
//   one; in_ready_o drops only once every stage holds a beat.
module triangle_transform_flat_shade_core #(
  parameter int unsigned SHADE_STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           v0_x_i,
  input  logic signed [31:0]           v0_y_i,
  input  logic signed [31:0]           v0_z_i,
  input  logic signed [31:0]           v1_x_i,
  input  logic signed [31:0]           v1_y_i,
  input  logic signed [31:0]           v1_z_i,
  input  logic signed [31:0]           v2_x_i,
  input  logic signed [31:0]           v2_y_i,
  input  logic signed [31:0]           v2_z_i,
  input  logic [15:0]                  material_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           w0_x_o,
  output logic signed [31:0]           w0_y_o,
  output logic signed [31:0]           w0_z_o,
  output logic signed [31:0]           w1_x_o,
  output logic signed [31:0]           w1_y_o,
  output logic signed [31:0]           w1_z_o,
  output logic signed [31:0]           w2_x_o,
  output logic signed [31:0]           w2_y_o,
  output logic signed [31:0]           w2_z_o,
  output logic [4:0]                   shade_bucket_o,
  output logic [15:0]                  tag_out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tts_pkg::CFGIW-1:0]    cfg_index_i,
  input  logic [tts_pkg::CFGDW-1:0]    cfg_data_i
);
  import tts_pkg::*;

  matrix_t mat_q;
  tri_t    in_tri;
  tri_t    xf_tri;
  tri_t    nm_tri;
  tri_t    sh_tri;
  face_t   nm_face;
  logic    xf_valid, xf_ready;
  logic    nm_valid, nm_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q.row[0].a <= XROW_A_RST;
      mat_q.row[0].b <= XROW_B_RST;
      mat_q.row[1].a <= YROW_A_RST;
      mat_q.row[1].b <= YROW_B_RST;
      mat_q.row[2].a <= ZROW_A_RST;
      mat_q.row[2].b <= ZROW_B_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_XROW_A: mat_q.row[0].a <= cfg_data_i;
        REG_XROW_B: mat_q.row[0].b <= cfg_data_i;
        REG_YROW_A: mat_q.row[1].a <= cfg_data_i;
        REG_YROW_B: mat_q.row[1].b <= cfg_data_i;
        REG_ZROW_A: mat_q.row[2].a <= cfg_data_i;
        REG_ZROW_B: mat_q.row[2].b <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_tri.v[0].x = v0_x_i;
    in_tri.v[0].y = v0_y_i;
    in_tri.v[0].z = v0_z_i;
    in_tri.v[1].x = v1_x_i;
    in_tri.v[1].y = v1_y_i;
    in_tri.v[1].z = v1_z_i;
    in_tri.v[2].x = v2_x_i;
    in_tri.v[2].y = v2_y_i;
    in_tri.v[2].z = v2_z_i;
    in_tri.tag    = material_tag_i;
  end

  tts_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_tri),
    .mat_i       (mat_q),
    .out_valid_o (xf_valid),
    .out_ready_i (xf_ready),
    .out_data_o  (xf_tri)
  );

  tts_normal u_normal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (xf_valid),
    .in_ready_o  (xf_ready),
    .in_data_i   (xf_tri),
    .out_valid_o (nm_valid),
    .out_ready_i (nm_ready),
    .out_data_o  (nm_tri),
    .out_face_o  (nm_face)
  );

  tts_shade #(
    .SHADE_STEPS (SHADE_STEPS)
  ) u_shade (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (nm_valid),
    .in_ready_o     (nm_ready),
    .in_data_i      (nm_tri),
    .in_face_i      (nm_face),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (sh_tri),
    .shade_bucket_o (shade_bucket_o)
  );

  assign w0_x_o    = sh_tri.v[0].x;
  assign w0_y_o    = sh_tri.v[0].y;
  assign w0_z_o    = sh_tri.v[0].z;
  assign w1_x_o    = sh_tri.v[1].x;
  assign w1_y_o    = sh_tri.v[1].y;
  assign w1_z_o    = sh_tri.v[1].z;
  assign w2_x_o    = sh_tri.v[2].x;
  assign w2_y_o    = sh_tri.v[2].y;
  assign w2_z_o    = sh_tri.v[2].z;
  assign tag_out_o = sh_tri.tag;

endmodule

// File: rtl/core/tts_xform.sv
// affine vertex transform with rounding, saturation and axis swap
module tts_xform (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tts_pkg::tri_t  in_data_i,
  input  tts_pkg::matrix_t mat_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tts_pkg::tri_t  out_data_o
);
  import tts_pkg::*;

  logic signed [2*CW-1:0] prod_d [3][3][3];
  logic signed [2*CW-1:0] prod_q [3][3][3];
  logic signed [CW-1:0]   ent [3][4];
  coord_t                 src [3][3];
  logic [TAGW-1:0]        tag_q;
  tri_t                   res_d;
  tri_t                   res_q;
  logic [1:0]             vld_q;
  logic [1:0]             en;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ent[r][0] = mat_i.row[r].a[63:32];
      ent[r][1] = mat_i.row[r].a[31:0];
      ent[r][2] = mat_i.row[r].b[63:32];
      ent[r][3] = mat_i.row[r].b[31:0];
    end
    for (int k = 0; k < 3; k++) begin
      src[k][0] = in_data_i.v[k].x;
      src[k][1] = in_data_i.v[k].y;
      src[k][2] = in_data_i.v[k].z;
    end
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_d[k][r][c] = ent[r][c] * src[k][c];
        end
      end
    end
  end

  always_comb begin
    logic signed [SUMW-1:0] acc;
    coord_t wld [3];
    for (int r = 0; r < 3; r++) wld[r] = '0;
    acc = '0;
    res_d = '0;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        // exact q32.32 sum, round half up to q16.16
        acc = SUMW'(prod_q[k][r][0]) + SUMW'(prod_q[k][r][1]) + SUMW'(prod_q[k][r][2])
            + (SUMW'(ent[r][3]) <<< 16) + SUMW'(32768);
        wld[r] = sat_wide(acc >>> 16);
      end
      res_d.v[k].x = wld[0];
      res_d.v[k].y = neg_sat(wld[2]);
      res_d.v[k].z = wld[1];
    end
    res_d.tag = tag_q;
  end

  always_comb begin
    en[1] = !vld_q[1] || out_ready_i;
    en[0] = !vld_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
      tag_q  <= in_data_i.tag;
    end
    if (en[1]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[1];
  assign out_data_o  = res_q;

endmodule

// File: rtl/core/tts_normal.sv
// face normal by cross product, its squared length and the sun dot product
module tts_normal (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tts_pkg::tri_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tts_pkg::tri_t  out_data_o,
  output tts_pkg::face_t out_face_o
);
  import tts_pkg::*;

  localparam int unsigned NST = 5;

  logic [NST-1:0]          vld_q;
  logic [NST-1:0]          en;
  tri_t                    tri_q [NST];
  logic signed [DIFFW-1:0] e_q [3];
  logic signed [DIFFW-1:0] f_q [3];
  logic signed [NW-1:0]    t_q [6];
  logic signed [NW-1:0]    n_q [3];
  logic [65:0]             hh_q [3];
  logic [64:0]             hl_q [3];
  logic [63:0]             ll_q [3];
  logic signed [DW-1:0]    d_q;
  face_t                   face_q;

  logic signed [DIFFW-1:0] e_d [3];
  logic signed [DIFFW-1:0] f_d [3];
  logic signed [NW-1:0]    t_d [6];
  logic signed [NW-1:0]    n_d [3];
  logic [65:0]             hh_d [3];
  logic [64:0]             hl_d [3];
  logic [63:0]             ll_d [3];
  logic signed [DW-1:0]    d_d;
  face_t                   face_d;

  // edge vectors from the first vertex
  always_comb begin
    e_d[0] = DIFFW'(in_data_i.v[1].x) - DIFFW'(in_data_i.v[0].x);
    e_d[1] = DIFFW'(in_data_i.v[1].y) - DIFFW'(in_data_i.v[0].y);
    e_d[2] = DIFFW'(in_data_i.v[1].z) - DIFFW'(in_data_i.v[0].z);
    f_d[0] = DIFFW'(in_data_i.v[2].x) - DIFFW'(in_data_i.v[0].x);
    f_d[1] = DIFFW'(in_data_i.v[2].y) - DIFFW'(in_data_i.v[0].y);
    f_d[2] = DIFFW'(in_data_i.v[2].z) - DIFFW'(in_data_i.v[0].z);
  end

  always_comb begin
    t_d[0] = e_q[1] * f_q[2];
    t_d[1] = e_q[2] * f_q[1];
    t_d[2] = e_q[2] * f_q[0];
    t_d[3] = e_q[0] * f_q[2];
    t_d[4] = e_q[0] * f_q[1];
    t_d[5] = e_q[1] * f_q[0];
    n_d[0] = t_q[0] - t_q[1];
    n_d[1] = t_q[2] - t_q[3];
    n_d[2] = t_q[4] - t_q[5];
  end

  // squares split into the upper 33 and lower 32 bits of the magnitude
  always_comb begin
    logic [64:0] mag;
    mag = '0;
    for (int c = 0; c < 3; c++) begin
      mag = n_q[c][NW-1] ? 65'(-n_q[c]) : 65'(n_q[c]);
      hh_d[c] = mag[64:32] * mag[64:32];
      hl_d[c] = 65'(mag[64:32]) * 65'(mag[31:0]);
      ll_d[c] = mag[31:0] * mag[31:0];
    end
    d_d = DW'(n_q[0]) * DW'(SUN_X) + DW'(n_q[1]) * DW'(SUN_Y) + DW'(n_q[2]) * DW'(SUN_Z);
  end

  always_comb begin
    logic [DMAGW-1:0] dm;
    dm = d_q[DW-1] ? DMAGW'(-d_q) : DMAGW'(d_q);
    face_d.len2 = '0;
    for (int c = 0; c < 3; c++) begin
      face_d.len2 = face_d.len2 + (LEN2W'(hh_q[c]) << 64)
                  + (LEN2W'(hl_q[c]) << 33) + LEN2W'(ll_q[c]);
    end
    face_d.d00 = dm[24:0] * dm[24:0];
    face_d.d01 = 49'(dm[24:0]) * 49'(dm[48:25]);
    face_d.d02 = 49'(dm[24:0]) * 49'(dm[72:49]);
    face_d.d11 = dm[48:25] * dm[48:25];
    face_d.d12 = dm[48:25] * dm[72:49];
    face_d.d22 = dm[72:49] * dm[72:49];
    face_d.pos = !d_q[DW-1] && (d_q != '0);
  end

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int s = NST - 2; s >= 0; s--) en[s] = !vld_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tri_q[0] <= in_data_i;
      e_q      <= e_d;
      f_q      <= f_d;
    end
    if (en[1]) begin
      tri_q[1] <= tri_q[0];
      t_q      <= t_d;
    end
    if (en[2]) begin
      tri_q[2] <= tri_q[1];
      n_q      <= n_d;
    end
    if (en[3]) begin
      tri_q[3] <= tri_q[2];
      hh_q     <= hh_d;
      hl_q     <= hl_d;
      ll_q     <= ll_d;
      d_q      <= d_d;
    end
    if (en[4]) begin
      tri_q[4] <= tri_q[3];
      face_q   <= face_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NST-1];
  assign out_data_o  = tri_q[NST-1];
  assign out_face_o  = face_q;

endmodule

// File: rtl/core/tts_shade.sv
// shade bucket by an exact squared compare, one bucket bit per stage
module tts_shade #(
  parameter int unsigned SHADE_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tts_pkg::tri_t                 in_data_i,
  input  tts_pkg::face_t                in_face_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tts_pkg::tri_t                 out_data_o,
  output logic [tts_pkg::BUCKETW-1:0]   shade_bucket_o
);
  import tts_pkg::*;

  localparam int unsigned NB   = $clog2(SHADE_STEPS + 1);
  localparam int unsigned NS   = NB + 2;
  localparam int unsigned MW   = NB + 8;
  localparam int unsigned SW   = LEN2W + 2 * NB + 34;
  localparam int unsigned BASE = AMBIENT_PCT * SHADE_STEPS + 50;
  localparam logic [63:0] QC   = 64'(BASE) * 64'(BASE) * 64'd10000;
  localparam logic [63:0] HC   = 64'(BASE) * 64'd1000000;
  localparam logic [63:0] GC   = 64'd100000000;
  localparam logic [63:0] KC   = 64'(DIFFUSE_PCT * SHADE_STEPS) * 64'(DIFFUSE_PCT * SHADE_STEPS);

  logic [NS-1:0]         vld_q;
  logic [NS-1:0]         en;
  tri_t                  tri_q [NS];
  logic [DSQW-1:0]       dsq_q;
  logic [DSQW-1:0]       dsq_d;
  // q = m^2 * 1e4 * len2 and h = m * 1e6 * len2 with m = 100*k - base
  logic signed [SW-1:0]  q_q  [NS];
  logic signed [SW-1:0]  h_q  [NS];
  logic signed [SW-1:0]  g3_q [NS];
  logic                  pos_q [NS];
  logic                  deg_q [NS];
  logic signed [SW-1:0]  x_q  [1:NS-1];
  logic [NB-1:0]         k_q  [1:NS-1];
  logic [NB-1:0]         k_t  [2:NS-1];
  logic signed [SW-1:0]  q_t  [2:NS-1];
  logic signed [SW-1:0]  h_t  [2:NS-1];
  logic                  acc  [2:NS-1];
  logic [NB-1:0]         bk;

  always_comb begin
    dsq_d = DSQW'(in_face_i.d00) + (DSQW'(in_face_i.d01) << 26)
          + (DSQW'(in_face_i.d11) << 50) + (DSQW'(in_face_i.d02) << 50)
          + (DSQW'(in_face_i.d12) << 75) + (DSQW'(in_face_i.d22) << 98);
  end

  always_comb begin
    logic [MW-1:0] m100;
    m100 = '0;
    for (int s = 2; s < NS; s++) begin
      k_t[s] = k_q[s-1] | (NB'(1) << (NB + 1 - s));
      m100   = MW'(k_t[s]) * MW'(100);
      q_t[s] = q_q[s-1] + (h_q[s-1] <<< (NB + 2 - s)) + (g3_q[s-1] <<< (2 * (NB + 1 - s)));
      h_t[s] = h_q[s-1] + (g3_q[s-1] <<< (NB + 1 - s));
      // trial bucket <= steps holds if offset <= 0, or lit and its square fits
      acc[s] = (k_t[s] <= NB'(SHADE_STEPS))
            && ((m100 <= MW'(BASE)) || (pos_q[s-1] && (q_t[s] <= x_q[s-1])));
    end
  end

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) en[s] = !vld_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tri_q[0] <= in_data_i;
      dsq_q    <= dsq_d;
      q_q[0]   <= $signed(SW'(in_face_i.len2) * SW'(QC));
      h_q[0]   <= -$signed(SW'(in_face_i.len2) * SW'(HC));
      g3_q[0]  <= $signed(SW'(in_face_i.len2) * SW'(GC));
      pos_q[0] <= in_face_i.pos;
      deg_q[0] <= (in_face_i.len2 == '0);
    end
    if (en[1]) begin
      tri_q[1] <= tri_q[0];
      q_q[1]   <= q_q[0];
      h_q[1]   <= h_q[0];
      g3_q[1]  <= g3_q[0];
      pos_q[1] <= pos_q[0];
      deg_q[1] <= deg_q[0];
      x_q[1]   <= $signed(SW'(dsq_q) * SW'(KC));
      k_q[1]   <= '0;
    end
    for (int s = 2; s < NS; s++) begin
      if (en[s]) begin
        tri_q[s] <= tri_q[s-1];
        g3_q[s]  <= g3_q[s-1];
        pos_q[s] <= pos_q[s-1];
        deg_q[s] <= deg_q[s-1];
        x_q[s]   <= x_q[s-1];
        if (acc[s]) begin
          q_q[s] <= q_t[s];
          h_q[s] <= h_t[s];
          k_q[s] <= k_t[s];
        end else begin
          q_q[s] <= q_q[s-1];
          h_q[s] <= h_q[s-1];
          k_q[s] <= k_q[s-1];
        end
      end
    end
  end

  assign bk             = deg_q[NS-1] ? NB'(SHADE_STEPS) : k_q[NS-1];
  assign shade_bucket_o = BUCKETW'(bk);
  assign in_ready_o     = en[0];
  assign out_valid_o    = vld_q[NS-1];
  assign out_data_o     = tri_q[NS-1];

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] |-> k_q[NS-1] <= NB'(SHADE_STEPS))
    else $error("search bucket above step count");

  a_unlit_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && !pos_q[NS-1] |-> k_q[NS-1] == NB'(BASE / 100))
    else $error("face turned from sun did not settle on ambient bucket");

  a_square_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] |-> !q_q[NS-1][SW-1])
    else $error("squared offset term went negative");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en[0] |-> vld_q[0] && vld_q[NS-1] && !out_ready_i)
    else $error("input stalled while pipeline has room");

endmodule
